[sv/f2i8q_pkg.sv]
package f2i8q_pkg;

   localparam int MANT_W         = 24;
   localparam int EXP_W          = 10;
   localparam int DIV_STAGES     = 7;
   localparam int BITS_PER_STAGE = 4;
   localparam int QUO_W          = DIV_STAGES * BITS_PER_STAGE;
   localparam int REM_W          = MANT_W + 1;
   localparam int STAGES         = DIV_STAGES + 4;
   localparam int MAG_W          = 11;
   localparam int INT_W          = 12;
   localparam int SUM_W          = 13;
   localparam int ZP_W           = 9;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_SCALE = 2'd1,
      STATUS_BAD_INPUT = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      REG_SCALE         = 2'd0,
      REG_ZERO_OFFSET   = 2'd1,
      REG_SIGNED_OUTPUT = 2'd2
   } reg_index_type;

   // Status, sign, zero flag and exponent that travel alongside the mantissa data.
   typedef struct packed {
      status_type               status;
      logic                     sign;
      logic                     zero;
      logic signed [EXP_W-1:0]  exp;
   } side_type;

   // Partial remainder, divisor and quotient bits of the mantissa division.
   typedef struct packed {
      logic [REM_W-1:0]  rem;
      logic [MANT_W-1:0] divisor;
      logic [QUO_W-1:0]  quo;
   } div_type;

endpackage

[sv/float_to_int8_affine_quantizer.sv]
// Affine quantizer from IEEE binary32 to an 8-bit integer. Each transfer on the
// req channel carries one binary32 element; it is divided by the binary32 scale,
// rounded to binary32 (nearest even), rounded to an integer (ties to even),
// offset by the zero point and saturated to 0..255 or, with signed_output set,
// to -128..127 as a two's-complement byte. Every element gets its own status:
// a scale that is zero, negative, infinite or NaN reports bad scale, and an
// infinite or NaN element reports bad input; the byte is zero on either error.
// The block takes one element per cycle unless rsp stalls with all stages full;
// each element passes through one unpack and normalize stage, seven stages of the
// mantissa divider at four quotient bits each, then a float rounding stage, an
// integer rounding stage and the offset and saturation stage that drives rsp.
// Every stage holds its own valid bit, so a stall on rsp only halts the input
// once all stages are full. The user must write registers through the csr port
// only while no transfer is in flight; the block itself does not enforce this.
module float_to_int8_affine_quantizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_value_bits,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_quantized_byte,
   output logic [1:0]  rsp_status,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data
);
   import f2i8q_pkg::*;

   typedef struct packed {
      logic [MANT_W-1:0]       mant;
      logic signed [EXP_W-1:0] exp;
   } norm_type;

   // Unpacks a finite magnitude and shifts its leading one to the top bit.
   function automatic norm_type normalize(input logic [30:0] mag);
      norm_type          n;
      logic [4:0]        lz;
      logic [MANT_W-1:0] m;
      logic signed [EXP_W-1:0] e;
      m  = (mag[30:23] == 8'd0) ? {1'b0, mag[22:0]} : {1'b1, mag[22:0]};
      e  = (mag[30:23] == 8'd0) ? -10'sd126 : ($signed({2'b00, mag[30:23]}) - 10'sd127);
      lz = 5'd0;
      for (int i = 0; i < MANT_W; i++) begin
         if (m[i]) begin
            lz = 5'(MANT_W - 1 - i);
         end
      end
      n.mant = m << lz;
      n.exp  = e - $signed({5'd0, lz});
      return n;
   endfunction

   // Configuration registers.
   logic [31:0]            scale_ff;
   logic signed [ZP_W-1:0] zp_ff;
   logic                   sgn_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= 32'h3F80_0000;
         zp_ff    <= '0;
         sgn_ff   <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (reg_index_type'(csr_index))
            REG_SCALE:         scale_ff <= csr_write_data;
            REG_ZERO_OFFSET:   zp_ff    <= $signed(csr_write_data[ZP_W-1:0]);
            REG_SIGNED_OUTPUT: sgn_ff   <= csr_write_data[0];
            default:           ;
         endcase
      end
   end

   // Per-stage valid bits. A stage loads when it is empty or when the stage after
   // it loads, which lets bubbles close up behind a stalled result.
   logic [STAGES-1:0] v_ff;
   logic [STAGES-1:0] v_in;
   logic [STAGES-1:0] stage_load;

   always_comb begin
      stage_load[STAGES-1] = !v_ff[STAGES-1] || !rsp_stall;
      for (int i = STAGES - 2; i >= 0; i--) begin
         stage_load[i] = !v_ff[i] || stage_load[i+1];
      end
      v_in[0] = stage_load[0] ? req_valid : v_ff[0];
      for (int i = 1; i < STAGES; i++) begin
         v_in[i] = stage_load[i] ? v_ff[i-1] : v_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_stall = !stage_load[0];

   // Stage 0: classify, unpack and normalize both operands.
   div_type  div0_in;
   div_type  div0_ff;
   side_type side0_in;
   side_type side0_ff;
   norm_type nv;
   norm_type ns;
   logic     scale_bad;

   always_comb begin
      nv        = normalize(req_value_bits[30:0]);
      ns        = normalize(scale_ff[30:0]);
      scale_bad = scale_ff[31] || (scale_ff[30:0] == 31'd0) || (&scale_ff[30:23]);
      if (scale_bad) begin
         side0_in.status = STATUS_BAD_SCALE;
      end else if (&req_value_bits[30:23]) begin
         side0_in.status = STATUS_BAD_INPUT;
      end else begin
         side0_in.status = STATUS_OK;
      end
      side0_in.sign   = req_value_bits[31] ^ scale_ff[31];
      side0_in.zero   = (req_value_bits[30:0] == 31'd0);
      side0_in.exp    = nv.exp - ns.exp;
      div0_in.rem     = {1'b0, nv.mant};
      div0_in.divisor = ns.mant;
      div0_in.quo     = '0;
   end

   always_ff @(posedge clock) begin
      if (stage_load[0]) begin
         div0_ff  <= div0_in;
         side0_ff <= side0_in;
      end
   end

   // Stages 1 to DIV_STAGES: the pipelined mantissa divider.
   div_type  dd [0:DIV_STAGES];
   side_type sd [0:DIV_STAGES];

   assign dd[0] = div0_ff;
   assign sd[0] = side0_ff;

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
      f2i8q_div_stage u_stage (
         .clock   (clock),
         .load    (stage_load[k+1]),
         .up_div  (dd[k]),
         .up_side (sd[k]),
         .dn_div  (dd[k+1]),
         .dn_side (sd[k+1])
      );
   end

   // Float rounding stage: the quotient lies in (0.5, 2), so its leading one is
   // in one of the top two bits. Round the 24-bit significand to nearest even.
   logic [MANT_W-1:0] fm_in;
   logic [MANT_W-1:0] fm_ff;
   side_type          fs_in;
   side_type          fs_ff;

   always_comb begin
      logic [QUO_W-1:0]  q;
      logic [MANT_W-1:0] s;
      logic              g;
      logic              st;
      logic [MANT_W:0]   s25;
      q     = dd[DIV_STAGES].quo;
      fs_in = sd[DIV_STAGES];
      if (q[QUO_W-1]) begin
         s  = q[QUO_W-1 -: MANT_W];
         g  = q[QUO_W-1-MANT_W];
         st = (|q[QUO_W-2-MANT_W:0]) || (|dd[DIV_STAGES].rem);
      end else begin
         s  = q[QUO_W-2 -: MANT_W];
         g  = q[QUO_W-2-MANT_W];
         st = (|q[QUO_W-3-MANT_W:0]) || (|dd[DIV_STAGES].rem);
         fs_in.exp = sd[DIV_STAGES].exp - 10'sd1;
      end
      s25 = {1'b0, s} + (MANT_W+1)'(g && (st || s[0]));
      if (s25[MANT_W]) begin
         fm_in     = s25[MANT_W:1];
         fs_in.exp = fs_in.exp + 10'sd1;
      end else begin
         fm_in = s25[MANT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_load[DIV_STAGES+1]) begin
         fm_ff <= fm_in;
         fs_ff <= fs_in;
      end
   end

   // Integer rounding stage. Magnitudes of 1024 and up saturate, since every
   // clamp bound lies well inside that; below one half the result is zero.
   logic signed [INT_W-1:0] t_in;
   logic signed [INT_W-1:0] t_ff;
   status_type              ts_ff;

   always_comb begin
      logic [MANT_W+10:0] x;
      logic [MAG_W-1:0]   mag;
      logic [3:0]         sh;
      x   = '0;
      sh  = 4'(fs_ff.exp + 10'sd1);
      if (fs_ff.zero || (fs_ff.exp < -10'sd1)) begin
         mag = '0;
      end else if (fs_ff.exp >= 10'sd10) begin
         mag = MAG_W'(1024);
      end else begin
         x   = (MANT_W+11)'(fm_ff) << sh;
         mag = x[MANT_W+10:MANT_W] +
               MAG_W'(x[MANT_W-1] && ((|x[MANT_W-2:0]) || x[MANT_W]));
      end
      t_in = fs_ff.sign ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   end

   always_ff @(posedge clock) begin
      if (stage_load[DIV_STAGES+2]) begin
         t_ff  <= t_in;
         ts_ff <= fs_ff.status;
      end
   end

   // Offset and saturation stage. Clamping before or after the zero point is
   // added gives the same value, so a single clamp to the output range does.
   logic [7:0]  byte_in;
   logic [7:0]  byte_ff;
   status_type  status_ff;

   always_comb begin
      logic signed [SUM_W-1:0] sum;
      logic signed [SUM_W-1:0] lo;
      logic signed [SUM_W-1:0] hi;
      sum = SUM_W'(t_ff) + SUM_W'(zp_ff);
      lo  = sgn_ff ? -13'sd128 : 13'sd0;
      hi  = sgn_ff ? 13'sd127 : 13'sd255;
      if (sum < lo) begin
         sum = lo;
      end else if (sum > hi) begin
         sum = hi;
      end
      byte_in = (ts_ff == STATUS_OK) ? sum[7:0] : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (stage_load[STAGES-1]) begin
         byte_ff   <= byte_in;
         status_ff <= ts_ff;
      end
   end

   assign rsp_valid          = v_ff[STAGES-1];
   assign rsp_quantized_byte = byte_ff;
   assign rsp_status         = status_ff;

   // An error result always carries a zero byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |-> rsp_quantized_byte == 8'd0)
      else $error("error result with nonzero byte");

   // The input halts only when every stage is full and the result is stalled.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall && (&v_ff))
      else $error("input stalled while the pipeline has room");

   // The status code is always one of the defined codes.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_OK) || (rsp_status == STATUS_BAD_SCALE) ||
                    (rsp_status == STATUS_BAD_INPUT))
      else $error("unused status code on output");

endmodule

[sv/f2i8q_div_stage.sv]
module f2i8q_div_stage (
   input  logic                clock,
   input  logic                load,
   input  f2i8q_pkg::div_type  up_div,
   input  f2i8q_pkg::side_type up_side,
   output f2i8q_pkg::div_type  dn_div,
   output f2i8q_pkg::side_type dn_side
);
   import f2i8q_pkg::*;

   div_type  div_in;
   div_type  div_ff;
   side_type side_ff;

   // Restoring division, a few quotient bits per stage.
   always_comb begin
      logic              ge;
      logic [MANT_W-1:0] r;
      div_in = up_div;
      for (int b = 0; b < BITS_PER_STAGE; b++) begin
         ge = div_in.rem >= {1'b0, div_in.divisor};
         r  = ge ? (div_in.rem[MANT_W-1:0] - div_in.divisor) : div_in.rem[MANT_W-1:0];
         div_in.rem = {r, 1'b0};
         div_in.quo = {div_in.quo[QUO_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         div_ff  <= div_in;
         side_ff <= up_side;
      end
   end

   assign dn_div  = div_ff;
   assign dn_side = side_ff;

endmodule

[tb/float_to_int8_affine_quantizer_tb.sv]
`timescale 1ns / 1ps

module float_to_int8_affine_quantizer_tb;
   import f2i8q_pkg::*;

   // Width of the exact fixed-point quotient: 60 fraction bits.
   localparam int FRAC_BITS   = 60;
   localparam int STALL_LIMIT = 4000;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_WAIT  = 24;

   typedef struct {
      logic [7:0] quantized_byte;
      status_type status;
   } quant_result_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_value_bits;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_quantized_byte;
   logic [1:0]  rsp_status;
   logic        csr_write_enable;
   logic [1:0]  csr_index;
   logic [31:0] csr_write_data;

   // Shadow copy of the block's registers, used by the predictor.
   logic [31:0]       scale_shadow;
   logic signed [8:0] zero_point_shadow;
   logic              signed_shadow;

   quant_result_type pending_results[$];
   int  error_count;
   int  quiet_cycles;
   bit  hold_request;
   bit  no_idle;

   float_to_int8_affine_quantizer i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_value_bits     (req_value_bits),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_quantized_byte (rsp_quantized_byte),
      .rsp_status         (rsp_status),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // Splits a finite binary32 pattern into a mantissa with its top bit at
   // position 23 and the exponent of that mantissa's least significant bit.
   function automatic void unpack_float(input logic [31:0] bits, output logic [23:0] mant,
                                        output int expo);
      if (bits[30:23] == 8'd0) begin
         mant = {1'b0, bits[22:0]};
         expo = -149;
      end else begin
         mant = {1'b1, bits[22:0]};
         expo = int'(bits[30:23]) - 150;
      end
      while (mant != 24'd0 && !mant[23]) begin
         mant = mant << 1;
         expo = expo - 1;
      end
   endfunction

   // Predicts one transfer on rsp from one element. The quotient is formed
   // exactly in fixed point, rounded to 24 significant bits (nearest even), then
   // clamped, rounded to an integer with ties to even, offset and saturated.
   function automatic quant_result_type quantize(input logic [31:0] value);
      quant_result_type  res;
      logic [23:0]       vm;
      logic [23:0]       sm;
      int                ve;
      int                se;
      int                dexp;
      int                msb;
      int                drop;
      int                lo;
      int                hi;
      int                ip;
      int                r;
      logic [127:0]      num;
      logic [127:0]      quo;
      logic [127:0]      remd;
      logic [127:0]      low_bits;
      logic [127:0]      half;
      logic [127:0]      kept;
      logic [127:0]      fx;
      logic [127:0]      mag;
      logic signed [129:0] sx;
      logic signed [129:0] lower_fx;
      logic signed [129:0] upper_fx;
      res.quantized_byte = 8'd0;
      if (scale_shadow[31] || scale_shadow[30:0] == 31'd0 || scale_shadow[30:23] == 8'hFF) begin
         res.status = STATUS_BAD_SCALE;
         return res;
      end
      if (value[30:23] == 8'hFF) begin
         res.status = STATUS_BAD_INPUT;
         return res;
      end
      res.status = STATUS_OK;
      fx = '0;
      if (value[30:0] != 31'd0) begin
         unpack_float(value, vm, ve);
         unpack_float(scale_shadow, sm, se);
         dexp = ve - se;
         if (dexp >= 11) begin
            // The quotient is at least 1024 and always lands on a clamp.
            fx = 128'd1 << (FRAC_BITS + 10);
         end else if (dexp > -4) begin
            num  = 128'(vm) << (dexp + FRAC_BITS);
            quo  = num / 128'(sm);
            remd = num % 128'(sm);
            msb  = 0;
            for (int i = 0; i < 128; i++) begin
               if (quo[i]) msb = i;
            end
            drop     = msb - 23;
            low_bits = quo & ((128'd1 << drop) - 1);
            half     = 128'd1 << (drop - 1);
            kept     = quo >> drop;
            if (low_bits > half || (low_bits == half && (remd != 0 || kept[0]))) begin
               kept = kept + 1;
            end
            fx = kept << drop;
         end
         // Quotients below 1/8 round to zero and are left at zero.
      end
      lo = signed_shadow ? -128 : 0;
      hi = signed_shadow ? 127 : 255;
      sx = value[31] ? -$signed({2'b00, fx}) : $signed({2'b00, fx});
      lower_fx = 130'(lo - int'(zero_point_shadow));
      upper_fx = 130'(hi - int'(zero_point_shadow));
      lower_fx = lower_fx <<< FRAC_BITS;
      upper_fx = upper_fx <<< FRAC_BITS;
      if (sx < lower_fx) sx = lower_fx;
      if (sx > upper_fx) sx = upper_fx;
      mag = sx < 0 ? 128'(-sx) : 128'(sx);
      ip  = int'(mag >> FRAC_BITS);
      low_bits = mag & ((128'd1 << FRAC_BITS) - 1);
      half     = 128'd1 << (FRAC_BITS - 1);
      if (low_bits > half || (low_bits == half && ip[0])) ip = ip + 1;
      r = (sx < 0 ? -ip : ip) + int'(zero_point_shadow);
      if (r < lo) r = lo;
      if (r > hi) r = hi;
      res.quantized_byte = r[7:0];
      return res;
   endfunction

   // The receiver stalls at random, holds off while a hold is requested, up to the
   // HOLD_CYCLES limit, and never stalls during the quiet stretch.
   always @(posedge clock) begin
      int hold_count;
      if (reset) begin
         rsp_stall  <= 1'b0;
         hold_count = 0;
      end else if (hold_request && hold_count < HOLD_CYCLES) begin
         rsp_stall  <= 1'b1;
         hold_count = hold_count + 1;
      end else begin
         if (!hold_request) hold_count = 0;
         rsp_stall <= no_idle ? 1'b0 : ($urandom_range(99) < 19);
      end
   end

   // Every transfer on rsp is compared with the oldest expected result.
   always @(posedge clock) begin
      quant_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected transfer, byte %h status %0d", $time,
                     rsp_quantized_byte, rsp_status);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_quantized_byte !== want.quantized_byte) begin
               $display("%0t: byte expected %h actual %h", $time, want.quantized_byte,
                        rsp_quantized_byte);
               error_count++;
            end
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status,
                        rsp_status);
               error_count++;
            end
         end
      end
   end

   // Watchdog: too many cycles without any transfer ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // Offers one element, with a random idle gap first, and records the
   // expected result when the transfer happens. Valid stays high afterwards.
   // A random gap before a few percent of the elements keeps the sender idle
   // in roughly a fifth of all cycles.
   task automatic send_value(input logic [31:0] value);
      int gap;
      gap = (no_idle || hold_request || $urandom_range(99) >= 7) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_value_bits <= value;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(quantize(value));
   endtask

   // Lowers valid and waits until every expected result has arrived, plus a
   // margin for the pipeline to empty.
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [31:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         REG_SCALE:         scale_shadow = data;
         REG_ZERO_OFFSET:   zero_point_shadow = data[8:0];
         REG_SIGNED_OUTPUT: signed_shadow = data[0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic [31:0] scale, input logic [8:0] zp, input logic sgn);
      write_reg(REG_SCALE, scale);
      write_reg(REG_ZERO_OFFSET, {23'd0, zp});
      write_reg(REG_SIGNED_OUTPUT, {31'd0, sgn});
   endtask

   // Random element: mostly values of a magnitude near the scale, so that the
   // quotient lands inside the rounding range; the rest raw bits or specials.
   function automatic logic [31:0] random_value();
      int pick;
      logic [7:0] e;
      pick = $urandom_range(99);
      if (pick < 70) begin
         e = scale_shadow[30:23] + 8'($urandom_range(12)) - 8'd4;
         if (e == 8'hFF) e = 8'hFE;
         return {1'($urandom), e, 23'($urandom)};
      end else if (pick < 78) begin
         // Exact halves, to hit the ties of the integer rounding.
         return {1'($urandom), 8'($urandom_range(126, 135)), 1'($urandom), 22'd0};
      end else if (pick < 85) begin
         return {1'($urandom), 8'hFF, 23'($urandom_range(1)) << $urandom_range(22)};
      end else begin
         return $urandom;
      end
   endfunction

   function automatic logic [31:0] random_scale();
      return {1'b0, 8'($urandom_range(115, 140)), 23'($urandom)};
   endfunction

   task automatic test_directed_values;
      logic [31:0] values[$];
      values = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000,
                 32'hFFFF_FFFF, 32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h0000_0001, 32'h8000_0001,
                 32'h3F00_0000, 32'h3FC0_0000, 32'h4020_0000, 32'hBF00_0000, 32'hBFC0_0000,
                 32'h42FF_0000, 32'h437F_8000, 32'h4396_0000, 32'hC348_0000, 32'h3F80_0001,
                 32'h3EFF_FFFF};
      foreach (values[i]) send_value(values[i]);
      drain();
   endtask

   task automatic test_register_extremes;
      logic [31:0] values[$];
      values = '{32'h4300_0000, 32'hC300_0000, 32'h3F00_0000, 32'h0000_0000, 32'h7F80_0000};
      // Signed range with the most negative zero point, then unsigned with the most positive.
      configure(32'h3F80_0000, 9'h100, 1'b1);
      foreach (values[i]) send_value(values[i]);
      drain();
      configure(32'h3F80_0000, 9'h0FF, 1'b0);
      foreach (values[i]) send_value(values[i]);
      drain();
      // Subnormal scale: the quotient far exceeds the output range and is clamped.
      configure(32'h0000_0001, 9'h180, 1'b1);
      foreach (values[i]) send_value(values[i]);
      send_value(32'h0000_0003);
      drain();
      configure(32'h7F7F_FFFF, 9'd0, 1'b0);
      send_value(32'h7F7F_FFFF);
      send_value(32'hFF7F_FFFF);
      drain();
   endtask

   task automatic test_bad_scales;
      logic [31:0] scales[$];
      scales = '{32'h0000_0000, 32'h8000_0000, 32'hBF80_0000, 32'h7F80_0000,
                 32'h7FC0_0000, 32'hFF80_0000, 32'h8000_0001};
      foreach (scales[i]) begin
         write_reg(REG_SCALE, scales[i]);
         send_value(32'h3F80_0000);
         send_value(32'h7F80_0000);
         drain();
      end
   endtask

   // The receiver holds off while elements keep coming, so the pipeline fills
   // and the block must stall its input.
   task automatic test_backpressure;
      configure(random_scale(), 9'($urandom), 1'($urandom));
      hold_request = 1'b1;
      repeat (60) send_value(random_value());
      hold_request = 1'b0;
      drain();
   endtask

   task automatic test_random_phases;
      for (int phase = 0; phase < 10; phase++) begin
         configure(random_scale(), 9'($urandom), 1'($urandom));
         no_idle = (phase == 4);
         repeat (105) send_value(random_value());
         no_idle = 1'b0;
         drain();
      end
   endtask

   initial begin
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_value_bits   <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= REG_SCALE;
      csr_write_data   <= '0;
      scale_shadow      = 32'h3F80_0000;
      zero_point_shadow = '0;
      signed_shadow     = 1'b0;
      error_count       = 0;
      hold_request      = 1'b0;
      no_idle           = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      repeat (DRAIN_WAIT) @(posedge clock);

      test_directed_values();
      test_register_extremes();
      test_bad_scales();
      test_backpressure();
      test_random_phases();

      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
